@@ rtl/sjf_pkg.sv @@
// Shared constants and controller/datapath handshake types for the SJF scheduler.
package sjf_pkg;

  localparam int MAX_PROCS = 64;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 8;
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic load;      // store the job on the input channel
    logic scan_clr;  // restart the slot scan
    logic rd;        // read the slot under the scan pointer
    logic adv;       // step the scan pointer
    logic emit;      // schedule the best job of the scan
    logic jump;      // move the clock to the earliest pending arrival
  } sjf_cmd_t;

  typedef struct packed {
    logic last_addr;   // scan pointer is on the last stored slot
    logic best_valid;  // scan found an arrived, unfinished job
    logic out_free;    // result register can take a beat this cycle
    logic final_pick;  // the pending pick is the last job of the set
  } sjf_sts_t;

endpackage

@@ rtl/sjf_job_if.sv @@
// Job input channel: valid/ready handshake with the job payload.
interface sjf_job_if;
  import sjf_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    job_id;
  logic [ARR_W-1:0]   arrival;
  logic [BURST_W-1:0] burst;
  logic               last_job;

  modport source (output valid, job_id, arrival, burst, last_job, input ready);
  modport sink   (input valid, job_id, arrival, burst, last_job, output ready);
endinterface

@@ rtl/sjf_res_if.sv @@
// Result output channel: valid/ready handshake with per-job timing results.
interface sjf_res_if;
  import sjf_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [TIME_W-1:0] wait_ticks;
  logic [TIME_W-1:0] turnaround_ticks;
  logic [TIME_W-1:0] response_ticks;
  logic              final_result;

  modport source (output valid, out_id, wait_ticks, turnaround_ticks, response_ticks,
                  final_result, input ready);
  modport sink   (input valid, out_id, wait_ticks, turnaround_ticks, response_ticks,
                  final_result, output ready);
endinterface

@@ rtl/sjf_ctrl.sv @@
// Sequencer for loading, slot scans and scheduling decisions.
module sjf_ctrl
  import sjf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  sjf_sts_t sts,
  output sjf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_clr = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.last_addr) begin
          state_next = S_DRAIN;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_DRAIN: begin
        // last slot is compared at this edge
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.best_valid) begin
          cmd.jump   = 1'b1;
          state_next = S_START;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.final_pick ? S_LOAD : S_START;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

@@ rtl/sjf_dp.sv @@
// Job store, minimum-burst scan unit, scheduling clock and result register.
module sjf_dp
  import sjf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sjf_cmd_t           cmd,
  output sjf_sts_t           sts,
  input  logic [ID_W-1:0]    job_id,
  input  logic [ARR_W-1:0]   arrival,
  input  logic [BURST_W-1:0] burst,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_id,
  output logic [TIME_W-1:0]  wait_ticks,
  output logic [TIME_W-1:0]  turnaround_ticks,
  output logic [TIME_W-1:0]  response_ticks,
  output logic               final_result
);

  localparam int ENTRY_W = ID_W + ARR_W + BURST_W;

  logic [ENTRY_W-1:0] mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] done;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  emitted;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  emitted_inc;
  logic [TIME_W-1:0] clock_now;
  logic [SLOT_W-1:0] addr;

  // read stage
  logic               rd_valid;
  logic               rd_done;
  logic [SLOT_W-1:0]  rd_slot;
  logic [ENTRY_W-1:0] rd_data;
  logic [ID_W-1:0]    rd_id;
  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_burst;

  // best-so-far of the current scan
  logic               best_valid;
  logic [SLOT_W-1:0]  best_slot;
  logic [ID_W-1:0]    best_id;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_burst;
  logic [ARR_W-1:0]   earliest;

  logic              cand;
  logic              arrived;
  logic              better;
  logic [TIME_W-1:0] wait_val;
  logic [TIME_W:0]   tat_sum;
  logic [TIME_W:0]   clk_sum;
  logic [TIME_W-1:0] tat_sat;
  logic [TIME_W-1:0] clk_sat;

  assign {rd_id, rd_arr, rd_burst} = rd_data;
  assign count_m1    = count - CNT_W'(1);
  assign emitted_inc = emitted + CNT_W'(1);

  assign cand    = rd_valid && !rd_done;
  assign arrived = {{(TIME_W-ARR_W){1'b0}}, rd_arr} <= clock_now;
  assign better  = !best_valid || (rd_burst < best_burst) ||
                   ((rd_burst == best_burst) && (rd_arr < best_arr));

  assign wait_val = clock_now - {{(TIME_W-ARR_W){1'b0}}, best_arr};
  assign tat_sum  = {1'b0, wait_val} + {{(TIME_W+1-BURST_W){1'b0}}, best_burst};
  assign clk_sum  = {1'b0, clock_now} + {{(TIME_W+1-BURST_W){1'b0}}, best_burst};
  assign tat_sat  = tat_sum[TIME_W] ? TIME_MAX : tat_sum[TIME_W-1:0];
  assign clk_sat  = clk_sum[TIME_W] ? TIME_MAX : clk_sum[TIME_W-1:0];

  assign sts.last_addr  = addr == count_m1[SLOT_W-1:0];
  assign sts.best_valid = best_valid;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.final_pick = emitted_inc == count;

  // job store
  always_ff @(posedge clk) begin
    if (cmd.load && (count < CNT_W'(MAX_PROCS))) begin
      mem[count[SLOT_W-1:0]] <= {job_id, arrival, burst};
    end
    if (cmd.rd) begin
      rd_data <= mem[addr];
      rd_done <= done[addr];
      rd_slot <= addr;
    end
  end

  // set bookkeeping: count, done flags, clock, scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      emitted   <= '0;
      done      <= '0;
      clock_now <= '0;
      addr      <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.rd;
      if (cmd.load && (count < CNT_W'(MAX_PROCS))) count <= count + CNT_W'(1);
      if (cmd.scan_clr) addr <= '0;
      else if (cmd.adv) addr <= addr + SLOT_W'(1);
      if (cmd.jump) clock_now <= {{(TIME_W-ARR_W){1'b0}}, earliest};
      if (cmd.emit) begin
        if (sts.final_pick) begin
          // set finished: clear for the next load
          count     <= '0;
          emitted   <= '0;
          done      <= '0;
          clock_now <= '0;
        end else begin
          emitted         <= emitted_inc;
          done[best_slot] <= 1'b1;
          clock_now       <= clk_sat;
        end
      end
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.scan_clr) begin
      best_valid <= 1'b0;
    end else if (cand && arrived && better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      earliest <= {ARR_W{1'b1}};
    end else if (cand && (rd_arr < earliest)) begin
      earliest <= rd_arr;
    end
    if (cand && arrived && better) begin
      best_slot  <= rd_slot;
      best_id    <= rd_id;
      best_arr   <= rd_arr;
      best_burst <= rd_burst;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id           <= best_id;
      wait_ticks       <= wait_val;
      turnaround_ticks <= tat_sat;
      response_ticks   <= wait_val;
      final_result     <= sts.final_pick;
    end
  end

endmodule

@@ rtl/sjf_nonpreemptive_scheduler.sv @@
// Non-preemptive shortest-job-first scheduler top level.
//
// Usage: jobs arrive on job_in as (job_id, arrival, burst), one per beat,
// while the block is loading. Up to 64 jobs are stored; further jobs are
// dropped. The beat with last_job set starts scheduling the stored set and
// job_in.ready stays low until the last result of the set has been placed
// in the result register.
// Each decision is one scan over the stored slots: a start state, one
// read per slot through the job memory's single read port, then drain and
// decide states. When no unfinished job has arrived the clock jumps to the
// earliest pending arrival and the scan repeats, so a result takes one or
// two scans.
// Results leave on res_out in schedule order; final_result marks the last.
// A stalled receiver holds the result register; the next scan still runs
// and the block waits at its decision until the register frees up.
// Reset (rst, synchronous) empties the set, clears the done flags and the
// scheduling clock and drops any held result. Stored job data is not
// cleared: only slots written in the current set are ever read.
module sjf_nonpreemptive_scheduler
  import sjf_pkg::*;
(
  input logic    clk,
  input logic    rst,
  sjf_job_if.sink   job_in,
  sjf_res_if.source res_out
);

  sjf_cmd_t cmd;
  sjf_sts_t sts;

  sjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (job_in.valid),
    .in_last  (job_in.last_job),
    .in_ready (job_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sjf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .job_id           (job_in.job_id),
    .arrival          (job_in.arrival),
    .burst            (job_in.burst),
    .out_valid        (res_out.valid),
    .out_ready        (res_out.ready),
    .out_id           (res_out.out_id),
    .wait_ticks       (res_out.wait_ticks),
    .turnaround_ticks (res_out.turnaround_ticks),
    .response_ticks   (res_out.response_ticks),
    .final_result     (res_out.final_result)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over a held beat");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res_out.valid)
    else $error("emitted result not presented");

  a_jump_nopick: assert property (@(posedge clk) disable iff (rst)
    cmd.jump |-> !sts.best_valid)
    else $error("clock jump while a job was picked");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.scan_clr || cmd.rd || cmd.emit || cmd.jump))
    else $error("job loaded during scheduling");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the non-preemptive shortest-job-first scheduler.
module testbench;
  import sjf_pkg::*;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic               is_last;
  } job_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wt_ticks;
    logic [TIME_W-1:0] tat_ticks;
    logic [TIME_W-1:0] rsp_ticks;
    logic              is_final;
  } sched_res_t;

  typedef enum int {MIX_DENSE, MIX_WIDE, MIX_TIES} job_mix_t;

  logic clk;
  logic rst;

  sjf_job_if job_in ();
  sjf_res_if res_out ();

  sjf_nonpreemptive_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .job_in  (job_in),
    .res_out (res_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  job_t       job_q[$];
  sched_res_t sched_q[$];

  // shadow of the job store
  logic [ID_W-1:0]    slot_id    [MAX_PROCS];
  logic [ARR_W-1:0]   slot_arr   [MAX_PROCS];
  logic [BURST_W-1:0] slot_burst [MAX_PROCS];
  logic               slot_done  [MAX_PROCS];
  int                 slot_cnt = 0;

  int errors = 0;
  int sets_scheduled = 0;
  int jobs_offered = 0;
  int jobs_dropped = 0;
  int results_checked = 0;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [BURST_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-BURST_W){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Store one accepted job; on the last job, schedule the set and queue its results.
  task automatic load_job(input job_t j);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] wt;
    logic [ARR_W:0]    earliest;
    int                pick;
    int                emitted;
    sched_res_t        r;
    jobs_offered++;
    if (slot_cnt < MAX_PROCS) begin
      slot_id[slot_cnt]    = j.id;
      slot_arr[slot_cnt]   = j.arrival;
      slot_burst[slot_cnt] = j.burst;
      slot_done[slot_cnt]  = 1'b0;
      slot_cnt++;
    end else begin
      jobs_dropped++;
    end
    if (!j.is_last) return;
    now = '0;
    emitted = 0;
    while (emitted < slot_cnt) begin
      pick = -1;
      earliest = '1;
      for (int i = 0; i < slot_cnt; i++) begin
        if (!slot_done[i]) begin
          if ({1'b0, slot_arr[i]} < earliest) earliest = {1'b0, slot_arr[i]};
          if ({{(TIME_W-ARR_W){1'b0}}, slot_arr[i]} <= now) begin
            if (pick < 0 || slot_burst[i] < slot_burst[pick] ||
                (slot_burst[i] == slot_burst[pick] && slot_arr[i] < slot_arr[pick]))
              pick = i;
          end
        end
      end
      if (pick < 0) begin
        // nothing has arrived yet: jump ahead
        now = TIME_W'(earliest);
      end else begin
        wt = now - {{(TIME_W-ARR_W){1'b0}}, slot_arr[pick]};
        r.id        = slot_id[pick];
        r.wt_ticks  = wt;
        r.tat_ticks = sat_add(wt, slot_burst[pick]);
        r.rsp_ticks = wt;
        r.is_final  = (emitted + 1 == slot_cnt);
        sched_q.push_back(r);
        now = sat_add(now, slot_burst[pick]);
        slot_done[pick] = 1'b1;
        emitted++;
      end
    end
    slot_cnt = 0;
    sets_scheduled++;
  endtask

  task automatic add_job(input int id, input int arrival, input int burst, input bit is_last);
    job_t j;
    j.id      = ID_W'(id);
    j.arrival = ARR_W'(arrival);
    j.burst   = BURST_W'(burst);
    j.is_last = is_last;
    job_q.push_back(j);
  endtask

  task automatic add_set(input int size, input job_mix_t mix);
    int arr;
    int bst;
    for (int k = 0; k < size; k++) begin
      case (mix)
        MIX_DENSE: begin
          arr = $urandom_range(0, 40);
          bst = $urandom_range(0, 24);
        end
        MIX_WIDE: begin
          arr = $urandom_range(0, 65535);
          bst = $urandom_range(0, 65535);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: arr = 0;
            1: arr = 1;
            2: arr = $urandom_range(2, 6);
            default: arr = 65535;
          endcase
          case ($urandom_range(0, 3))
            0: bst = 0;
            1: bst = 1;
            2: bst = 7;
            default: bst = 65535;
          endcase
        end
      endcase
      add_job($urandom_range(0, 255), arr, bst, k == size - 1);
    end
  endtask

  // Job driver: bursts of beats separated by random gaps.
  job_t cur_job;
  int   burst_left;
  int   gap_left;

  always @(posedge clk) begin
    if (rst) begin
      job_in.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (job_in.valid && job_in.ready) load_job(cur_job);
      if (!job_in.valid || job_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          job_in.valid <= 1'b0;
        end else if (job_q.size() > 0) begin
          cur_job = job_q.pop_front();
          job_in.valid    <= 1'b1;
          job_in.job_id   <= cur_job.id;
          job_in.arrival  <= cur_job.arrival;
          job_in.burst    <= cur_job.burst;
          job_in.last_job <= cur_job.is_last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1, 2, 3: gap_left = 0;
              4, 5:       gap_left = $urandom_range(1, 4);
              6:          gap_left = $urandom_range(5, 15);
              default:    gap_left = $urandom_range(20, 40);
            endcase
          end
        end else begin
          job_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: the stall pattern changes at random intervals, with long holds.
  int hold_left;
  int rx_mode;
  int mode_left;
  int rx_phase;
  int rx_beats;

  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      rx_phase = 0;
      rx_beats = 0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        rx_beats++;
        // hold off long enough for the job input to back up
        if (rx_beats == 12 || rx_beats == 160) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_out.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        rx_phase++;
        case (rx_mode)
          0:       res_out.ready <= 1'b1;
          1:       res_out.ready <= 1'($urandom_range(0, 1));
          2:       res_out.ready <= (rx_phase % 5) < 3;
          default: res_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  sched_res_t exp_r;

  always @(posedge clk) begin
    if (!rst && res_out.valid && res_out.ready) begin
      if (sched_q.size() == 0) begin
        $error("result beat with nothing expected, out_id %0d", res_out.out_id);
        errors++;
      end else begin
        exp_r = sched_q.pop_front();
        check_field("out_id", 32'(exp_r.id), 32'(res_out.out_id));
        check_field("wait_ticks", 32'(exp_r.wt_ticks), 32'(res_out.wait_ticks));
        check_field("turnaround_ticks", 32'(exp_r.tat_ticks),
                    32'(res_out.turnaround_ticks));
        check_field("response_ticks", 32'(exp_r.rsp_ticks), 32'(res_out.response_ticks));
        check_field("final_result", 32'(exp_r.is_final), 32'(res_out.final_result));
        results_checked++;
      end
    end
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int rand_items;
    int set_idx;
    int size;
    job_mix_t mix;

    rst = 1'b1;
    job_in.valid    = 1'b0;
    job_in.job_id   = '0;
    job_in.arrival  = '0;
    job_in.burst    = '0;
    job_in.last_job = 1'b0;
    res_out.ready   = 1'b0;

    // single job, all zero
    add_job(0, 0, 0, 1);
    // single job at the field maxima: clock must jump to its arrival
    add_job(255, 65535, 65535, 1);
    // full ties resolve by slot; zero burst does not advance the clock
    add_job(1, 0, 5, 0);
    add_job(2, 0, 5, 0);
    add_job(3, 1, 5, 0);
    add_job(4, 2, 0, 1);
    // an idle gap before the first arrival forces a clock jump
    add_job(10, 100, 3, 0);
    add_job(11, 50, 65535, 0);
    add_job(12, 65535, 1, 1);
    // equal bursts, both arrived: earlier arrival wins
    add_job(20, 5, 7, 0);
    add_job(21, 3, 7, 0);
    add_job(22, 0, 20, 1);

    rand_items = 0;
    set_idx = 0;
    while (rand_items < 290) begin
      if (set_idx == 3) begin
        // overfill the store: two dropped jobs, the last one carries last_job
        size = MAX_PROCS + 2;
      end else if ($urandom_range(0, 9) == 0) begin
        size = $urandom_range(9, 20);
      end else begin
        size = $urandom_range(1, 8);
      end
      case ($urandom_range(0, 2))
        0:       mix = MIX_DENSE;
        1:       mix = MIX_WIDE;
        default: mix = MIX_TIES;
      endcase
      add_set(size, mix);
      rand_items += size;
      set_idx++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || job_in.valid || sched_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (sched_q.size() != 0) begin
      $error("%0d results never arrived", sched_q.size());
      errors++;
    end

    $display("Scheduled %0d job sets from %0d accepted jobs (%0d dropped on a full store).",
             sets_scheduled, jobs_offered, jobs_dropped);
    $display("Checked %0d result beats under random stalls and long receiver holds.",
             results_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sjf_nonpreemptive_scheduler.f @@
rtl/sjf_pkg.sv
rtl/sjf_job_if.sv
rtl/sjf_res_if.sv
rtl/sjf_ctrl.sv
rtl/sjf_dp.sv
rtl/sjf_nonpreemptive_scheduler.sv
tb/sv/testbench.sv
